// ----- src/sle_pkg.sv -----
package sle_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int LEN_W      = $clog2(CAPACITY + 1);
   localparam int KIND_W     = 3;
   localparam int POS_W      = 11;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;
   localparam int SUM_W      = 64;
   localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam int REQ_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STAT_W + POS_W + SUM_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 3'd0,
      KIND_REMOVE  = 3'd1,
      KIND_REVERSE = 3'd2,
      KIND_FIND    = 3'd3,
      KIND_SUM     = 3'd4
   } sle_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_MISSING = 2'd2,
      STAT_FULL    = 2'd3
   } sle_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_SWEEP,
      S_DRAIN,
      S_PUT,
      S_REV_RLO,
      S_REV_RHI,
      S_REV_WLO,
      S_REV_WHI,
      S_DONE
   } sle_state_type;

   typedef struct packed {
      logic load;
      logic sweep_init;
      logic sweep_rd;
      logic put;
      logic rev_init;
      logic rd_lo;
      logic rd_hi;
      logic wr_lo;
      logic wr_hi;
      logic finish;
   } sle_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              range_err;
      logic              full;
      logic              len_zero;
      logic              len_le1;
      logic              ins_empty;
      logic              sweep_last;
      logic              rev_next;
      logic              rsp_free;
   } sle_stat_type;

endpackage

// ----- src/sle_ram.sv -----
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/sle_datapath.sv -----
module sle_datapath
   import sle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  sle_cmd_type           cmd,
   output sle_stat_type          stat,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [VAL_W-1:0]      val_ff, val_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]     rd_addr_ff, rd_addr_in;
   logic                  hit_ff, hit_in;
   logic [POS_W-1:0]      at_ff, at_in;
   logic [SUM_W-1:0]      acc_ff, acc_in;
   logic [ADDR_W-1:0]     lo_ff, lo_in;
   logic [ADDR_W-1:0]     hi_ff, hi_in;
   logic [VAL_W-1:0]      tmp_ff, tmp_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]     len_m1;
   logic                  is_insert;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [VAL_W-1:0]      ram_wdata;
   logic                  ram_re;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [VAL_W-1:0]      ram_q;
   sle_status_type        status;

   assign len_m1    = ADDR_W'(length_ff - LEN_W'(1));
   assign is_insert = (kind_ff == KIND_INSERT);

   assign stat.kind       = kind_ff;
   assign stat.range_err  = CMP_W'(pos_ff) > CMP_W'(length_ff);
   assign stat.full       = (length_ff == LEN_W'(CAPACITY));
   assign stat.len_zero   = (length_ff == '0);
   assign stat.len_le1    = (length_ff <= LEN_W'(1));
   assign stat.ins_empty  = CMP_W'(pos_ff) == CMP_W'(length_ff);
   assign stat.sweep_last = is_insert ? (idx_ff == ADDR_W'(pos_ff)) : (idx_ff == len_m1);
   assign stat.rev_next   = ((ADDR_W + 1)'(lo_ff) + (ADDR_W + 1)'(2)) < (ADDR_W + 1)'(hi_ff);
   assign stat.rsp_free   = !rsp_vld_ff || rsp_tready;

   always_comb begin
      unique case (kind_ff)
         KIND_INSERT: begin
            if (stat.range_err) begin
               status = STAT_RANGE;
            end else if (stat.full) begin
               status = STAT_FULL;
            end else begin
               status = STAT_OK;
            end
         end
         KIND_REMOVE, KIND_FIND: begin
            status = hit_ff ? STAT_OK : STAT_MISSING;
         end
         default: begin
            status = STAT_OK;
         end
      endcase
   end

   always_comb begin
      ram_re    = cmd.sweep_rd || cmd.rd_lo || cmd.rd_hi;
      ram_raddr = cmd.rd_lo ? lo_ff : (cmd.rd_hi ? hi_ff : idx_ff);
   end

   // Sweep writes move the element that has just come back from memory one
   // place up (insert) or one place down (remove, after the match).
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = rd_addr_ff;
      ram_wdata = ram_q;
      priority if (cmd.put) begin
         ram_we    = 1'b1;
         ram_waddr = ADDR_W'(pos_ff);
         ram_wdata = val_ff;
      end else if (cmd.wr_lo) begin
         ram_we    = 1'b1;
         ram_waddr = lo_ff;
      end else if (cmd.wr_hi) begin
         ram_we    = 1'b1;
         ram_waddr = hi_ff;
         ram_wdata = tmp_ff;
      end else if (rd_vld_ff && is_insert) begin
         ram_we    = 1'b1;
         ram_waddr = rd_addr_ff + ADDR_W'(1);
      end else if (rd_vld_ff && kind_ff == KIND_REMOVE && hit_ff) begin
         ram_we    = 1'b1;
         ram_waddr = rd_addr_ff - ADDR_W'(1);
      end else begin
         ram_we    = 1'b0;
      end
   end

   always_comb begin
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      length_in   = length_ff;
      idx_in      = idx_ff;
      rd_vld_in   = cmd.sweep_rd;
      rd_addr_in  = rd_addr_ff;
      hit_in      = hit_ff;
      at_in       = at_ff;
      acc_in      = acc_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      tmp_in      = tmp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (cmd.load) begin
         kind_in = req_tuser;
         pos_in  = req_tdata[POS_W-1:0];
         val_in  = req_tdata[POS_W +: VAL_W];
         hit_in  = 1'b0;
         at_in   = '1;
         acc_in  = '0;
      end

      if (cmd.sweep_init) begin
         idx_in = is_insert ? len_m1 : '0;
      end

      if (cmd.sweep_rd) begin
         rd_addr_in = idx_ff;
         idx_in     = is_insert ? (idx_ff - ADDR_W'(1)) : (idx_ff + ADDR_W'(1));
      end

      if (rd_vld_ff) begin
         unique case (kind_ff)
            KIND_REMOVE: begin
               if (!hit_ff && ram_q == val_ff) begin
                  hit_in = 1'b1;
               end
            end
            KIND_FIND: begin
               if (!hit_ff && ram_q == val_ff) begin
                  hit_in = 1'b1;
                  at_in  = POS_W'(rd_addr_ff);
               end
            end
            KIND_SUM: begin
               acc_in = acc_ff + (SUM_W'($signed(ram_q)) ^ SUM_W'(rd_addr_ff));
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end

      if (cmd.rev_init) begin
         lo_in = '0;
         hi_in = len_m1;
      end
      if (cmd.rd_hi) begin
         tmp_in = ram_q;
      end
      if (cmd.wr_hi) begin
         lo_in = lo_ff + ADDR_W'(1);
         hi_in = hi_ff - ADDR_W'(1);
      end

      if (cmd.finish) begin
         if (is_insert && status == STAT_OK) begin
            length_in = length_ff + LEN_W'(1);
         end else if (kind_ff == KIND_REMOVE && hit_ff) begin
            length_in = length_ff - LEN_W'(1);
         end
         rsp_vld_in  = 1'b1;
         rsp_data_in = RSP_DATA_W'({acc_ff, at_ff, status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         length_ff  <= length_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      rd_addr_ff  <= rd_addr_in;
      hit_ff      <= hit_in;
      at_ff       <= at_in;
      acc_ff      <= acc_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
   end

   sle_ram #(
      .WIDTH(VAL_W),
      .DEPTH(CAPACITY)
   ) u_elements (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_q)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LEN_W'(CAPACITY))
      else $error("element count above capacity");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_rd |-> LEN_W'(idx_ff) < length_ff)
      else $error("sweep read beyond the stored elements");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && kind_ff == KIND_REMOVE && hit_ff)
      |=> length_ff == $past(length_ff) - LEN_W'(1))
      else $error("successful remove did not shorten the sequence");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && at_ff != '1) |-> (kind_ff == KIND_FIND && status == STAT_OK))
      else $error("position reported for a request that found nothing");
`endif

endmodule

// ----- src/sle_ctrl.sv -----
module sle_ctrl
   import sle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  sle_stat_type stat,
   output sle_cmd_type  cmd
);

   sle_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            unique case (stat.kind)
               KIND_INSERT: begin
                  if (stat.range_err || stat.full) begin
                     state_in = S_DONE;
                  end else if (stat.ins_empty) begin
                     state_in = S_PUT;
                  end else begin
                     cmd.sweep_init = 1'b1;
                     state_in       = S_SWEEP;
                  end
               end
               KIND_REMOVE, KIND_FIND, KIND_SUM: begin
                  if (stat.len_zero) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.sweep_init = 1'b1;
                     state_in       = S_SWEEP;
                  end
               end
               KIND_REVERSE: begin
                  if (stat.len_le1) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.rev_init = 1'b1;
                     state_in     = S_REV_RLO;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last element read is handled by the datapath in this cycle.
            state_in = (stat.kind == KIND_INSERT) ? S_PUT : S_DONE;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_DONE;
         end
         S_REV_RLO: begin
            cmd.rd_lo = 1'b1;
            state_in  = S_REV_RHI;
         end
         S_REV_RHI: begin
            cmd.rd_hi = 1'b1;
            state_in  = S_REV_WLO;
         end
         S_REV_WLO: begin
            cmd.wr_lo = 1'b1;
            state_in  = S_REV_WHI;
         end
         S_REV_WHI: begin
            cmd.wr_hi = 1'b1;
            state_in  = stat.rev_next ? S_REV_RLO : S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/sequence_list_engine_core.sv -----
// Ordered sequence of up to CAPACITY signed 32-bit values held in a single-port-read,
// single-port-write element memory. Each request transaction yields exactly one response
// transaction, and one request is worked on at a time. Remove, find and xor-sum read the
// elements one per cycle, then wait out the memory's read latency and send the response;
// on an empty sequence they go straight to the response. Insert moves the elements from
// the end down to the position up one place each and then writes the new value; it writes
// the value directly when it appends at the end, and goes straight to the response when
// it is rejected. Reverse swaps pairs from both ends inward: it reads the low element,
// reads the high element, writes the low slot and writes the high slot. The response
// waits while an earlier response is still held by the response side. A finished response
// waits in an output register, and a new request is accepted as soon as it is registered.
module sequence_list_engine_core
   import sle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[10:0], value[42:11], zero fill
   input  logic [KIND_W-1:0]     req_tuser,  // req_type[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], found_at[12:2],
                                             // weighted_sum[76:13], zero fill
);

   sle_cmd_type  cmd;
   sle_stat_type stat;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sle_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule
